>>> hw/rtl/ffba_pkg.sv
// Package for the FIFO free-list block allocator.
// Holds shared widths, request/status codes, register indexes and the pool request struct.
// No dependencies.
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int ID_W           = 10;
    localparam int CNT_PORT_W     = 11;
    localparam int DEF_MAX_BLOCKS = 1024;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] REG_PRIMARY_SIZE   = 2'd0;
    localparam logic [1:0] REG_SECONDARY_SIZE = 2'd1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic            alloc;
        logic            free;
        logic [ID_W-1:0] id;
    } pool_req_t;

endpackage

>>> hw/rtl/ffba_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ffba_pool.sv
// One FIFO free list: head/tail/count registers around a list RAM.
// Depends on ffba_pkg and ffba_ram. A refill marks the list as identity-filled; entries
// written since the refill are tracked by a write count from the refill tail.
`timescale 1ns / 1ps

module ffba_pool #(
    parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int AW         = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    parameter int CW         = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_load,
    input  logic [ffba_pkg::CNT_PORT_W-1:0] cfg_size,
    input  ffba_pkg::pool_req_t             req,
    output logic [CW-1:0]                   count,
    output logic [ffba_pkg::ID_W-1:0]       rd_id
);
    import ffba_pkg::*;

    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   wr_cnt_reg, wr_cnt_next;
    logic            use_mem_reg;
    logic [ID_W-1:0] ident_reg;
    logic [ID_W-1:0] ram_rdata;

    logic [31:0] size32, n32, head32, base32, dist32;
    logic [AW-1:0] fill_tail;
    logic [AW-1:0] head_inc, tail_inc;

    always_comb begin
        size32    = 32'(cfg_size);
        n32       = (size32 > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : size32;
        fill_tail = (n32 == 32'(MAX_BLOCKS)) ? '0 : AW'(n32);
        head32    = 32'(head_reg);
        base32    = 32'(base_reg);
        dist32    = (head32 >= base32) ? (head32 - base32)
                                       : (head32 + 32'(MAX_BLOCKS) - base32);
        head_inc  = (head32 == 32'(MAX_BLOCKS - 1)) ? '0 : AW'(head32 + 32'd1);
        tail_inc  = (32'(tail_reg) == 32'(MAX_BLOCKS - 1)) ? '0
                                                           : AW'(32'(tail_reg) + 32'd1);

        head_next   = head_reg;
        tail_next   = tail_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        wr_cnt_next = wr_cnt_reg;

        if (cfg_load) begin
            head_next   = '0;
            tail_next   = fill_tail;
            base_next   = fill_tail;
            count_next  = CW'(n32);
            wr_cnt_next = '0;
        end else if (req.alloc) begin
            head_next  = head_inc;
            count_next = count_reg - CW'(1);
        end else if (req.free) begin
            tail_next  = tail_inc;
            count_next = count_reg + CW'(1);
            if (32'(wr_cnt_reg) != 32'(MAX_BLOCKS)) begin
                wr_cnt_next = wr_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            base_reg   <= '0;
            count_reg  <= '0;
            wr_cnt_reg <= '0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            base_reg   <= base_next;
            count_reg  <= count_next;
            wr_cnt_reg <= wr_cnt_next;
        end
    end

    // entry not written since refill reads as its own index
    always_ff @(posedge aclk) begin
        if (req.alloc) begin
            use_mem_reg <= (dist32 < 32'(wr_cnt_reg));
            ident_reg   <= head32[ID_W-1:0];
        end
    end

    ffba_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_list (
        .aclk  (aclk),
        .we    (req.free),
        .waddr (tail_reg),
        .wdata (req.id),
        .re    (req.alloc),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign count = count_reg;
    assign rd_id = use_mem_reg ? ram_rdata : ident_reg;

endmodule

>>> hw/rtl/fifo_free_list_block_allocator_unit.sv
// Top level of the two-pool FIFO free-list block allocator.
// Depends on ffba_pkg and ffba_pool (which uses ffba_ram).
//
// Usage:
//   s_* channel: one request per accepted item (allocate, free or query) naming a pool.
//   m_* channel: exactly one result per request, in request order.
//   cfg_* channel: index 0 writes the primary pool size, index 1 the secondary;
//   a write refills that pool with ids 0..size-1 at once (no sweep). Other indexes
//   are ignored. Write configuration only while no request is in flight.
// Pipeline: an accepted request is registered in the p1 stage along with the list RAM
//   read, then in the output register.
// Throughput: one request per cycle sustained while m_ready is high; the head/tail/count update of each
//   pool is a read-modify-write of registers in its pool controller.
// Reset: both pools empty (count zero), pointers zero.
// Stall: when m_ready is low the result and the request behind it hold;
//   s_ready drops once both stages are occupied.
`timescale 1ns / 1ps

module fifo_free_list_block_allocator_unit #(
    parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic                            s_pool_sel,
    input  logic [ffba_pkg::ID_W-1:0]       s_freed_id,
    input  logic [ffba_pkg::CNT_PORT_W-1:0] s_want_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [ffba_pkg::ID_W-1:0]       m_granted_id,
    output logic [ffba_pkg::CNT_PORT_W-1:0] m_free_count,
    output logic                            m_enough,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [ffba_pkg::CNT_PORT_W-1:0] cfg_data
);
    import ffba_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    logic [CW-1:0]   cnt0, cnt1, sel_cnt;
    logic [ID_W-1:0] rd0, rd1;
    pool_req_t       req0, req1, req_sel;
    logic            accept, adv, empty, full, is_alloc, is_free;
    logic [31:0]     sel_cnt32;
    status_t         st;

    logic                  p1_valid_reg;
    status_t               p1_status_reg;
    logic                  p1_pool_reg;
    logic                  p1_grant_reg;
    logic [CNT_PORT_W-1:0] p1_count_reg;
    logic                  p1_enough_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic [CNT_PORT_W-1:0] out_count_reg;
    logic                  out_enough_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || m_ready;
    assign s_ready   = !p1_valid_reg || adv;
    assign accept    = s_valid && s_ready;

    always_comb begin
        sel_cnt   = s_pool_sel ? cnt1 : cnt0;
        sel_cnt32 = 32'(sel_cnt);
        empty     = (sel_cnt32 == 32'd0);
        full      = (sel_cnt32 >= 32'(MAX_BLOCKS));
        is_alloc  = (s_req_type == REQ_ALLOC);
        is_free   = (s_req_type == REQ_FREE);

        st = STATUS_OK;
        if (is_alloc && empty) begin
            st = STATUS_EMPTY;
        end else if (is_free && full) begin
            st = STATUS_FULL;
        end

        req_sel.alloc = accept && is_alloc && !empty;
        req_sel.free  = accept && is_free && !full;
        req_sel.id    = s_freed_id;

        req0 = req_sel;
        req1 = req_sel;
        if (s_pool_sel) begin
            req0.alloc = 1'b0;
            req0.free  = 1'b0;
        end else begin
            req1.alloc = 1'b0;
            req1.free  = 1'b0;
        end
    end

    ffba_pool #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW),
        .CW         (CW)
    ) u_pool0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_load (cfg_valid && cfg_ready && (cfg_index == REG_PRIMARY_SIZE)),
        .cfg_size (cfg_data),
        .req      (req0),
        .count    (cnt0),
        .rd_id    (rd0)
    );

    ffba_pool #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW),
        .CW         (CW)
    ) u_pool1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_load (cfg_valid && cfg_ready && (cfg_index == REG_SECONDARY_SIZE)),
        .cfg_size (cfg_data),
        .req      (req1),
        .count    (cnt1),
        .rd_id    (rd1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_status_reg <= st;
            p1_pool_reg   <= s_pool_sel;
            p1_grant_reg  <= is_alloc && !empty;
            p1_count_reg  <= sel_cnt32[CNT_PORT_W-1:0];
            p1_enough_reg <= (sel_cnt32 >= 32'(s_want_count));
        end
        if (adv && p1_valid_reg) begin
            out_status_reg <= p1_status_reg;
            out_id_reg     <= p1_grant_reg ? (p1_pool_reg ? rd1 : rd0) : '0;
            out_count_reg  <= p1_count_reg;
            out_enough_reg <= p1_enough_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_granted_id = out_id_reg;
    assign m_free_count = out_count_reg;
    assign m_enough     = out_enough_reg;

endmodule
